/* rtl/kc2d_pkg.sv */
// Shared types and constants of the 3x3 convolution block.
// No dependencies; every other file in rtl/ but kc2d_line_store imports this package.
package kc2d_pkg;

  localparam int unsigned KSIZE      = 3;
  localparam int unsigned NCH        = 3;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = NCH * CH_W;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned KROW_W     = KSIZE * COEF_W;
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned COLSUM_W   = 26;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned COL_W      = 11;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned OCOL_W     = 10;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned CNT_W      = 4;

  localparam logic [COL_W-1:0]  RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [ROW_W-1:0]  RST_FRAME_HEIGHT = 16'd1024;
  localparam logic [KROW_W-1:0] RST_COEF_TOP     = 48'h0;
  localparam logic [KROW_W-1:0] RST_COEF_MID     = 48'h0000_4000_0000;
  localparam logic [KROW_W-1:0] RST_COEF_BOT     = 48'h0;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOT     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] sample_c2;
    logic [CH_W-1:0] sample_c1;
    logic [CH_W-1:0] sample_c0;
  } in_pix_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_c0;
    logic signed [SUM_W-1:0] sum_c1;
    logic signed [SUM_W-1:0] sum_c2;
    logic [OCOL_W-1:0]       out_column;
    logic [ROW_W-1:0]        out_row;
    logic                    frame_end;
  } out_res_t;

  typedef struct packed {
    logic [OCOL_W-1:0] out_column;
    logic [ROW_W-1:0]  out_row;
    logic              frame_end;
  } out_meta_t;

  // one window column, index 0 is the top kernel row
  typedef logic [KSIZE-1:0][PIX_W-1:0]    pix_col_t;
  typedef logic [KSIZE-1:0][COEF_W-1:0]   coef_col_t;
  typedef logic [NCH-1:0][COLSUM_W-1:0]   col_sum_t;

  typedef struct packed {
    logic shift;  // window column moves one cell left
    logic calc;   // register products
    logic zero;   // left neighbor lies outside the frame
    logic sum;    // register column sums
  } cell_ctl_t;

endpackage

/* rtl/kernel_2d_convolution.sv */
// 3x3 convolution of a raster RGB stream: row stores, a chain of window cells, result queue.
// A request passes the request stage, the row stores, the window cells and the final add into the result queue.
// Throughput: one request per cycle while in_stall_o is low; the 8-entry result queue sets how long
// the input keeps flowing while the output is stalled.
// Reset: window, scan position and registers return to defaults; row stores keep old data.
// Depends on kc2d_pkg, kc2d_line_store, kc2d_cell, kc2d_out_fifo.
module kernel_2d_convolution import kc2d_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned CHANNELS  = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_pix_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_res_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  // ---------------- register file ----------------
  logic [COL_W-1:0]  cfg_width_q;
  logic [ROW_W-1:0]  cfg_height_q;
  logic [KROW_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;
  logic              reg_wr;
  reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_FRAME_WIDTH;
      cfg_height_q <= RST_FRAME_HEIGHT;
      coef_top_q   <= RST_COEF_TOP;
      coef_mid_q   <= RST_COEF_MID;
      coef_bot_q   <= RST_COEF_BOT;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  cfg_width_q  <= pwdata[COL_W-1:0];
        REG_FRAME_HEIGHT: cfg_height_q <= pwdata[ROW_W-1:0];
        REG_COEF_TOP:     coef_top_q   <= pwdata[KROW_W-1:0];
        REG_COEF_MID:     coef_mid_q   <= pwdata[KROW_W-1:0];
        REG_COEF_BOT:     coef_bot_q   <= pwdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(cfg_width_q);
      REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_height_q);
      REG_COEF_TOP:     prdata = DATA_W'(coef_top_q);
      REG_COEF_MID:     prdata = DATA_W'(coef_mid_q);
      REG_COEF_BOT:     prdata = DATA_W'(coef_bot_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------- scan position and request stage ----------------
  logic [COL_W-1:0] scan_col_q, scan_col_d, w_eff, c_cur;
  logic [ROW_W-1:0] scan_row_q, scan_row_d, h_eff, r_cur;
  logic             accept, emit_now, access_now;
  logic [PIX_W-1:0] cur_now;
  logic [AW-1:0]    addr_now;
  out_meta_t        meta_now;
  logic [CNT_W-1:0] used_q, fifo_cnt;
  logic             push, pop;

  assign w_eff = (cfg_width_q == '0) ? COL_W'(1) :
                 ((32'(cfg_width_q) > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : cfg_width_q);
  assign h_eff = (cfg_height_q == '0) ? ROW_W'(1) : cfg_height_q;
  assign c_cur = (scan_col_q > w_eff) ? w_eff : scan_col_q;
  assign r_cur = (scan_row_q > h_eff) ? h_eff : scan_row_q;

  assign access_now = (c_cur < w_eff);
  assign emit_now   = (r_cur != '0) && (c_cur != '0);
  assign addr_now   = AW'(c_cur);
  // drain column and drain row feed zeros
  assign cur_now    = (access_now && r_cur < h_eff) ?
                      {in_data_i.sample_c2, in_data_i.sample_c1, in_data_i.sample_c0} : '0;

  assign meta_now.out_column = OCOL_W'(c_cur - 1'b1);
  assign meta_now.out_row    = r_cur - 1'b1;
  assign meta_now.frame_end  = (r_cur == h_eff) && (c_cur == w_eff);

  // every emitting request reserves a queue slot at acceptance
  assign in_stall_o = (used_q == CNT_W'(FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  always_comb begin
    scan_col_d = scan_col_q;
    scan_row_d = scan_row_q;
    if (accept) begin
      if (c_cur >= w_eff) begin
        scan_col_d = '0;
        scan_row_d = (r_cur >= h_eff) ? '0 : r_cur + 1'b1;
      end else begin
        scan_col_d = c_cur + 1'b1;
        scan_row_d = r_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_col_q <= '0;
      scan_row_q <= '0;
      used_q     <= '0;
    end else begin
      scan_col_q <= scan_col_d;
      scan_row_q <= scan_row_d;
      used_q     <= used_q + CNT_W'(accept && emit_now) - CNT_W'(pop);
    end
  end

  // ---------------- pipeline control ----------------
  logic             s1_vld_q;
  logic [4:1]       emit_q;
  out_meta_t        meta_q [1:4];
  logic [2:1]       lt2_q;
  logic [PIX_W-1:0] s1_cur_q;
  logic             s1_access_q, s1_top_ok_q, s1_mid_ok_q;
  logic [AW-1:0]    s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      emit_q   <= '0;
    end else begin
      s1_vld_q  <= accept;
      emit_q[1] <= accept && emit_now;
      emit_q[4:2] <= emit_q[3:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q    <= cur_now;
      s1_access_q <= access_now;
      s1_top_ok_q <= access_now && (r_cur >= ROW_W'(2));
      s1_mid_ok_q <= access_now && (r_cur != '0);
      s1_addr_q   <= addr_now;
      meta_q[1]   <= meta_now;
      lt2_q[1]    <= (c_cur < COL_W'(2));
    end
    meta_q[2] <= meta_q[1];
    meta_q[3] <= meta_q[2];
    meta_q[4] <= meta_q[3];
    lt2_q[2]  <= lt2_q[1];
  end

  // ---------------- row stores ----------------
  logic [PIX_W-1:0] rd_older, rd_newer;

  kc2d_line_store #(.DEPTH(MAX_WIDTH), .AW(AW), .DW(PIX_W)) u_store_newer (
    .clk_i     (clk_i),
    .wr_en_i   (accept && access_now),
    .wr_addr_i (addr_now),
    .wr_data_i (cur_now),
    .rd_en_i   (accept && access_now),
    .rd_addr_i (addr_now),
    .rd_data_o (rd_newer)
  );

  // the older row takes what the newer row held, in the cycle after the read
  kc2d_line_store #(.DEPTH(MAX_WIDTH), .AW(AW), .DW(PIX_W)) u_store_older (
    .clk_i     (clk_i),
    .wr_en_i   (s1_vld_q && s1_access_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (rd_newer),
    .rd_en_i   (accept && access_now),
    .rd_addr_i (addr_now),
    .rd_data_o (rd_older)
  );

  // ---------------- window cell chain ----------------
  pix_col_t new_col;
  pix_col_t chain_in  [KSIZE];
  pix_col_t chain_out [KSIZE];
  col_sum_t col_sum   [KSIZE];

  assign new_col[0] = s1_top_ok_q ? rd_older : '0;
  assign new_col[1] = s1_mid_ok_q ? rd_newer : '0;
  assign new_col[2] = s1_cur_q;

  for (genvar kx = 0; kx < KSIZE; kx++) begin : g_cell
    coef_col_t coef_col;
    cell_ctl_t ctl;

    assign coef_col[0] = coef_top_q[COEF_W*kx +: COEF_W];
    assign coef_col[1] = coef_mid_q[COEF_W*kx +: COEF_W];
    assign coef_col[2] = coef_bot_q[COEF_W*kx +: COEF_W];

    assign ctl.shift = s1_vld_q;
    assign ctl.calc  = emit_q[2];
    assign ctl.zero  = (kx == 0) ? lt2_q[2] : 1'b0;
    assign ctl.sum   = emit_q[3];

    if (kx == KSIZE - 1) begin : g_head
      assign chain_in[kx] = new_col;
    end else begin : g_link
      assign chain_in[kx] = chain_out[kx+1];
    end

    kc2d_cell #(.CHANNELS(CHANNELS)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .col_i  (chain_in[kx]),
      .coef_i (coef_col),
      .col_o  (chain_out[kx]),
      .sum_o  (col_sum[kx])
    );
  end

  // ---------------- final add and result queue ----------------
  logic signed [SUM_W-1:0] total [NCH];
  out_res_t                res;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      total[ch] = '0;
      for (int kx = 0; kx < KSIZE; kx++) begin
        total[ch] = total[ch] + SUM_W'($signed(col_sum[kx][ch]));
      end
    end
  end

  assign res.sum_c0     = total[0];
  assign res.sum_c1     = total[1];
  assign res.sum_c2     = total[2];
  assign res.out_column = meta_q[4].out_column;
  assign res.out_row    = meta_q[4].out_row;
  assign res.frame_end  = meta_q[4].frame_end;
  assign push           = emit_q[4];

  kc2d_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .count_o     (fifo_cnt)
  );

  // ---------------- checks ----------------
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit_now) |-> ##4 push)
    else $error("result did not reach the queue after four cycles");

  a_slot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) == 32'(fifo_cnt) + 32'($countones(emit_q)))
    else $error("reserved slots differ from queued plus in-flight results");

  a_left_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_q[2] && lt2_q[2]) |-> (meta_q[2].out_column == '0))
    else $error("left neighbor masked away from the first column");

endmodule

/* rtl/kc2d_line_store.sv */
// One row store: single write port, one registered read port.
// Depends on nothing but its parameters.
module kc2d_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 24
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  // read-first: a read and write at the same address return the old entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/kc2d_cell.sv */
// One window column cell: holds three pixels, multiplies by its kernel column,
// sums the column per channel. Depends on kc2d_pkg.
module kc2d_cell import kc2d_pkg::*; #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  pix_col_t  col_i,
  input  coef_col_t coef_i,
  output pix_col_t  col_o,
  output col_sum_t  sum_o
);

  pix_col_t                col_q;
  logic signed [PROD_W-1:0] prod_d [KSIZE][NCH];
  logic signed [PROD_W-1:0] prod_q [KSIZE][NCH];
  col_sum_t                sum_d, sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (ctl_i.shift) begin
      col_q <= col_i;
    end
  end

  always_comb begin
    logic [CH_W-1:0]          px;
    logic signed [COEF_W-1:0] cf;
    px = '0;
    cf = '0;
    for (int ky = 0; ky < KSIZE; ky++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        px = col_q[ky][CH_W*ch +: CH_W];
        cf = $signed(coef_i[ky]);
        prod_d[ky][ch] = '0;
        if (ch < CHANNELS && !ctl_i.zero) begin
          prod_d[ky][ch] = PROD_W'($signed({1'b0, px})) * PROD_W'(cf);
        end
      end
    end
  end

  always_comb begin
    logic signed [COLSUM_W-1:0] acc;
    acc = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      acc = '0;
      for (int ky = 0; ky < KSIZE; ky++) begin
        acc = acc + COLSUM_W'(prod_q[ky][ch]);
      end
      sum_d[ch] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.calc) begin
      prod_q <= prod_d;
    end
    if (ctl_i.sum) begin
      sum_q <= sum_d;
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

/* rtl/kc2d_out_fifo.sv */
// Result queue between the arithmetic pipeline and the output channel.
// Depends on kc2d_pkg; the caller never pushes into a full queue.
module kc2d_out_fifo import kc2d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  out_res_t         push_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_res_t         out_data_o,
  output logic [CNT_W-1:0] count_o
);

  out_res_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CNT_W'(push_i) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_data_o = mem[rd_ptr_q];
  assign count_o    = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |-> (count_q != CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

endmodule

/* verif/kernel_2d_convolution_test.sv */
// Self-checking testbench for kernel_2d_convolution: raster frames of random and patterned
// pixels, random kernels and frame sizes, and checks of every weighted 3x3 sum, in order.
// Depends on kc2d_pkg and the RTL under rtl/.
module kernel_2d_convolution_test;
  import kc2d_pkg::*;

  localparam int unsigned MAX_W        = 1024;
  localparam int unsigned SETTLE_CYC   = 12;
  localparam int unsigned RANDOM_COUNT = 550;
  localparam longint      CYCLE_LIMIT  = 200_000;

  // Tracks the scan, the two line stores and the window, and holds the sums still due.
  class conv_sum_board;
    logic [PIX_W-1:0]  older_line [MAX_W];
    logic [PIX_W-1:0]  newer_line [MAX_W];
    logic [PIX_W-1:0]  win [KSIZE][KSIZE];
    logic [COL_W-1:0]  col_pos;
    logic [ROW_W-1:0]  row_pos;
    logic [COL_W-1:0]  width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [KROW_W-1:0] krow [KSIZE];
    out_res_t          sums_due [$];
    int                n_fail;

    function new();
      for (int i = 0; i < MAX_W; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      foreach (win[y, x]) win[y][x] = '0;
      col_pos    = '0;
      row_pos    = '0;
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      krow[0]    = RST_COEF_TOP;
      krow[1]    = RST_COEF_MID;
      krow[2]    = RST_COEF_BOT;
      n_fail     = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = v[COL_W-1:0];
        REG_FRAME_HEIGHT: height_reg = v[ROW_W-1:0];
        REG_COEF_TOP:     krow[0]    = v[KROW_W-1:0];
        REG_COEF_MID:     krow[1]    = v[KROW_W-1:0];
        REG_COEF_BOT:     krow[2]    = v[KROW_W-1:0];
        default: ;
      endcase
    endfunction

    function bit at_origin();
      return col_pos == '0 && row_pos == '0;
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    function void take_pixel(in_pix_t px);
      int unsigned             w, h, c, r;
      logic [PIX_W-1:0]        cur, top, mid;
      longint                  acc;
      logic signed [COEF_W-1:0] k;
      logic [SUM_W-1:0]        s [NCH];
      out_res_t                res;

      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      h = height_reg;
      if (h == 0) h = 1;
      // a size shrunk mid-frame pulls the scan back to the drain column/row
      c = (col_pos > w) ? w : col_pos;
      r = (row_pos > h) ? h : row_pos;

      cur = (r < h && c < w) ? px : '0;
      top = '0;
      mid = '0;
      if (c < w) begin
        top = (r >= 2) ? older_line[c] : '0;
        mid = (r >= 1) ? newer_line[c] : '0;
        older_line[c] = newer_line[c];
        newer_line[c] = cur;
      end

      for (int y = 0; y < KSIZE; y++) begin
        win[y][0] = win[y][1];
        win[y][1] = win[y][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = cur;

      if (r >= 1 && c >= 1) begin
        for (int ch = 0; ch < NCH; ch++) begin
          acc = 0;
          for (int y = 0; y < KSIZE; y++) begin
            for (int x = 0; x < KSIZE; x++) begin
              // left column lies outside the frame for output column 0
              if (!(x == 0 && c < 2)) begin
                k = krow[y][COEF_W*x +: COEF_W];
                acc += longint'(win[y][x][CH_W*ch +: CH_W]) * longint'(k);
              end
            end
          end
          s[ch] = acc[SUM_W-1:0];
        end
        res.sum_c0     = s[0];
        res.sum_c1     = s[1];
        res.sum_c2     = s[2];
        res.out_column = OCOL_W'(c - 1);
        res.out_row    = ROW_W'(r - 1);
        res.frame_end  = (r == h && c == w);
        sums_due = {sums_due, res};
      end

      if (c >= w) begin
        c = 0;
        r = (r >= h) ? 0 : r + 1;
      end else begin
        c++;
      end
      col_pos = COL_W'(c);
      row_pos = ROW_W'(r);
    endfunction

    function void match_sum(out_res_t got);
      out_res_t want;
      if (sums_due.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected result: col %0d row %0d sums %0d %0d %0d end %0b",
                   got.out_column, got.out_row, $signed(got.sum_c0), $signed(got.sum_c1),
                   $signed(got.sum_c2), got.frame_end);
        return;
      end
      want = sums_due.pop_front();
      if (got.sum_c0 !== want.sum_c0 || got.sum_c1 !== want.sum_c1 ||
          got.sum_c2 !== want.sum_c2 || got.out_column !== want.out_column ||
          got.out_row !== want.out_row || got.frame_end !== want.frame_end) begin
        n_fail++;
        if (n_fail <= 10)
          $display({"mismatch: expected col %0d row %0d sums %0d %0d %0d end %0b, ",
                    "got col %0d row %0d sums %0d %0d %0d end %0b"},
                   want.out_column, want.out_row, $signed(want.sum_c0),
                   $signed(want.sum_c1), $signed(want.sum_c2), want.frame_end,
                   got.out_column, got.out_row, $signed(got.sum_c0),
                   $signed(got.sum_c1), $signed(got.sum_c2), got.frame_end);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  in_pix_t           in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_res_t          out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  conv_sum_board sb;
  bit            tx_gaps_on = 1'b1;
  bit            rx_calm    = 1'b0;
  int unsigned   burst_left = 0;
  int unsigned   pixels_sent = 0;
  int unsigned   rx_left = 0;
  int unsigned   rx_mode = 0;
  longint        cycle_count = 0;

  kernel_2d_convolution #(
    .MAX_WIDTH(MAX_W),
    .CHANNELS (NCH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receiver: switches between free flow, light random, periodic and heavy stalling
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_calm ? $urandom_range(0, 1) : $urandom_range(0, 3);
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    case (rx_mode)
      0:       out_stall = 1'b0;
      1:       out_stall = ($urandom_range(0, 3) == 0);
      2:       out_stall = ((rx_left % 16) < 6);
      default: out_stall = ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.match_sum(out_data);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_pix_t pick_pixel();
    logic [PIX_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '1;
      1:       v = '0;
      default: v = PIX_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic in_pix_t pattern_pixel(int unsigned i);
    logic [PIX_W-1:0] v;
    case (i % 5)
      0:       v = 24'hFF_FF_FF;
      1:       v = 24'h00_00_00;
      2:       v = 24'hAA_55_AA;
      3:       v = 24'h55_AA_55;
      default: v = 24'h01_80_FE;
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] pick_krow();
    case ($urandom_range(0, 7))
      0:       return 64'h7FFF_7FFF_7FFF;
      1:       return 64'h8000_8000_8000;
      2:       return 64'h0;
      3:       return 64'h0000_4000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_pixel(input in_pix_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid = 1'b0;
        in_data  = pick_pixel();
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_data  = p;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    sb.take_pixel(p);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pixels(input int unsigned n, input bit patterned);
    for (int unsigned i = 0; i < n; i++)
      send_pixel(patterned ? pattern_pixel(i) : pick_pixel());
  endtask

  // keep streaming until the scan wraps back to row 0, column 0
  task automatic finish_frame(input bit patterned);
    int unsigned i;
    i = 0;
    do begin
      send_pixel(patterned ? pattern_pixel(i) : pick_pixel());
      i++;
    end while (!sb.at_origin());
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input logic [DATA_W-1:0] w, h, top, mid, bot);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_BOT, bot);
  endtask

  initial begin
    int unsigned w_pick, h_pick, h_eff, frame_len, cut, start_count;

    sb       = new();
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // small frame, extreme coefficients, patterned pixels (drain data is garbage on purpose)
    configure(3, 2, 64'h7FFF_7FFF_7FFF, 64'h8000_8000_8000, 64'h0001_FFFF_4000);
    finish_frame(1'b1);
    // zero width and height act as 1x1; reset kernel, centre tap only
    configure(0, 0, DATA_W'(RST_COEF_TOP), DATA_W'(RST_COEF_MID), DATA_W'(RST_COEF_BOT));
    finish_frame(1'b1);
    // shrink the frame while a scan sits at the new drain column and row
    configure(4, 3, pick_krow(), pick_krow(), pick_krow());
    send_pixels(7, 1'b1);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 1);
    finish_frame(1'b1);

    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_COUNT) begin
      tx_gaps_on = ($urandom_range(0, 4) != 0);
      w_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(21, 80) : $urandom_range(1, 20);
      h_pick = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
      h_eff  = (h_pick == 0) ? 1 : h_pick;
      configure(DATA_W'(w_pick), DATA_W'(h_pick), pick_krow(), pick_krow(), pick_krow());
      if ($urandom_range(0, 5) == 0) begin
        // shrinking mid-frame only reads store entries already written this frame
        frame_len = (w_pick + 1) * (h_eff + 1);
        cut = $urandom_range(1, frame_len - 1);
        send_pixels(cut, 1'b0);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, DATA_W'($urandom_range(0, w_pick)));
        write_reg(REG_FRAME_HEIGHT, DATA_W'($urandom_range(0, h_eff)));
      end
      finish_frame(1'b0);
    end

    // out-of-range width saturates: one full widest row plus its drain, then a narrow finish
    tx_gaps_on = 1'b1;
    configure(DATA_W'(2047), DATA_W'(1), pick_krow(), pick_krow(), pick_krow());
    send_pixels(MAX_W + 2, 1'b0);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, DATA_W'(2));
    finish_frame(1'b0);
    // tall frame, one pixel wide, at near full rate; cut short by a smaller height
    tx_gaps_on = 1'b0;
    rx_calm    = 1'b1;
    configure(DATA_W'(1), DATA_W'(65535), pick_krow(), pick_krow(), pick_krow());
    send_pixels(40, 1'b0);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, DATA_W'(3));
    finish_frame(1'b0);

    wait_idle();
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
